/* design/fwbt_pkg.sv */
// ----------------------------------------------------------------------------
// fwbt_pkg: shared types and constants for the fixed weight basis table
// Operation codes, configuration register indexes, field widths, and the
// nibble bit-count helper used by the build walk.
// ----------------------------------------------------------------------------
package fwbt_pkg;

  localparam int unsigned MAX_SITES_DEF   = 16;
  localparam int unsigned TABLE_DEPTH_DEF = 16384;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_BUILD = 2'd0,
    OP_STATE = 2'd1,
    OP_INDEX = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SITE_COUNT = 2'd0,
    CFG_ONES_COUNT = 2'd1
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] SITE_COUNT_RST = 5'd16;
  localparam logic [CFG_W-1:0] ONES_COUNT_RST = 5'd8;

  // number of set bits in one nibble
  function automatic logic [2:0] nib_ones(input logic [3:0] n);
    logic [2:0] c;
    begin
      c = 3'(n[0]) + 3'(n[1]) + 3'(n[2]) + 3'(n[3]);
      return c;
    end
  endfunction

endpackage

/* design/fixed_weight_basis_table.sv */
// ----------------------------------------------------------------------------
// fixed_weight_basis_table: ascending table of fixed Hamming weight strings
// A build beat walks every value below 2^min(site_count, MAX_SITES), one
// value per cycle, and writes each value with ones_count set bits into the
// table RAM; it returns the entry count (saturating at TABLE_DEPTH). An
// index-of-string beat binary-searches the stored entries through the single
// RAM port; each probe puts out the address, takes the registered read and
// compares. One beat is worked at a time; the next beat is taken as soon as
// the result sits in the output register. The table is not cleared after
// reset; entries at or beyond the count are never read.
// ----------------------------------------------------------------------------
module fixed_weight_basis_table #(
  parameter int unsigned MAX_SITES   = fwbt_pkg::MAX_SITES_DEF,
  parameter int unsigned TABLE_DEPTH = fwbt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fwbt_pkg::OP_W-1:0]     operation_i,
  input  logic [fwbt_pkg::VAL_W-1:0]    operand_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fwbt_pkg::VAL_W-1:0]    result_value_o,
  output logic                          found_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fwbt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fwbt_pkg::CFG_W-1:0]    cfg_data_i
);

  import fwbt_pkg::*;

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned LW  = (CW > VAL_W) ? CW : VAL_W;
  localparam int unsigned VW  = (MAX_SITES > VAL_W) ? MAX_SITES : VAL_W;
  localparam int unsigned PW  = $clog2(MAX_SITES + 1);
  localparam int unsigned OW  = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned WKW = MAX_SITES + 1;
  localparam int unsigned NIB = (MAX_SITES + 3) / 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_READ,
    ST_SRCH_ADDR,
    ST_SRCH_CMP,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [CFG_W-1:0]       site_q;
  logic [CFG_W-1:0]       ones_q;
  logic [CW-1:0]          cnt_q;
  logic [WKW-1:0]         walk_q;
  logic [CW-1:0]          lo_q;
  logic [CW-1:0]          hix_q;
  logic [AW-1:0]          mid_q;
  logic [VAL_W-1:0]       arg_q;
  logic [VAL_W-1:0]       res_q;
  logic                   ok_q;
  logic                   out_valid_q;
  logic [VAL_W-1:0]       out_res_q;
  logic                   out_ok_q;

  // build walk
  logic [CFG_W-1:0]       site_eff;
  logic [WKW-1:0]         limit;
  logic [WKW-1:0]         walk_nx;
  logic                   build_last;
  logic [NIB*4-1:0]       walk_pad;
  logic [PW-1:0]          pc;
  logic                   match;
  logic                   room;

  // ram
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [MAX_SITES-1:0]   ram_rdata;

  // lookups
  logic [LW-1:0]          op_ext;
  logic [LW-1:0]          cnt_ext;
  logic [LW-1:0]          mid_ext;
  logic                   in_range;
  logic [CW:0]            mid_sum;
  logic [AW-1:0]          mid_w;
  logic [VW-1:0]          rd_ext;
  logic [VW-1:0]          arg_ext;
  logic                   in_acc;
  logic                   out_free;

  assign site_eff   = (site_q > CFG_W'(MAX_SITES)) ? CFG_W'(MAX_SITES) : site_q;
  assign limit      = WKW'(1) << site_eff;
  assign walk_nx    = walk_q + WKW'(1);
  assign build_last = (walk_nx == limit);
  assign walk_pad   = (NIB*4)'(walk_q[MAX_SITES-1:0]);

  always_comb begin
    pc = '0;
    for (int i = 0; i < NIB; i++) begin
      pc = pc + PW'(nib_ones(walk_pad[i*4 +: 4]));
    end
  end

  assign match  = (OW'(pc) == OW'(ones_q));
  assign room   = (cnt_q != CW'(TABLE_DEPTH));
  assign ram_we = (state_q == ST_BUILD) && match && room;

  assign op_ext   = LW'(operand_value_i);
  assign cnt_ext  = LW'(cnt_q);
  assign mid_ext  = LW'(mid_q);
  assign in_range = (op_ext < cnt_ext);

  // floor((lo + hi_exclusive - 1) / 2); only used while lo < hi_exclusive
  assign mid_sum = (CW+1)'(lo_q) + (CW+1)'(hix_q) - (CW+1)'(1);
  assign mid_w   = mid_sum[AW:1];

  assign rd_ext  = VW'(ram_rdata);
  assign arg_ext = VW'(arg_q);

  always_comb begin
    case (state_q)
      ST_BUILD:     ram_addr = cnt_q[AW-1:0];
      ST_SRCH_ADDR: ram_addr = mid_w;
      default:      ram_addr = op_ext[AW-1:0];
    endcase
  end

  fwbt_ram #(
    .WIDTH (MAX_SITES),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (walk_q[MAX_SITES-1:0]),
    .rdata_o (ram_rdata)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      site_q      <= SITE_COUNT_RST;
      ones_q      <= ONES_COUNT_RST;
      cnt_q       <= '0;
      walk_q      <= '0;
      lo_q        <= '0;
      hix_q       <= '0;
      mid_q       <= '0;
      arg_q       <= '0;
      res_q       <= '0;
      ok_q        <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_ok_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SITE_COUNT: site_q <= cfg_data_i;
          CFG_ONES_COUNT: ones_q <= cfg_data_i;
          default: ;
        endcase
      end

      // in ST_DONE the output register is reloaded below instead
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            arg_q <= operand_value_i;
            res_q <= '0;
            ok_q  <= 1'b0;
            case (op_e'(operation_i))
              OP_BUILD: begin
                cnt_q   <= '0;
                walk_q  <= '0;
                state_q <= ST_BUILD;
              end
              OP_STATE: begin
                // address already on the RAM port this cycle
                state_q <= in_range ? ST_READ : ST_DONE;
              end
              OP_INDEX: begin
                lo_q    <= '0;
                hix_q   <= cnt_q;
                state_q <= ST_SRCH_ADDR;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_BUILD: begin
          if (ram_we) begin
            cnt_q <= cnt_q + CW'(1);
          end
          walk_q <= walk_nx;
          if (build_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_READ: begin
          res_q   <= rd_ext[VAL_W-1:0];
          ok_q    <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_SRCH_ADDR: begin
          if (lo_q < hix_q) begin
            mid_q   <= mid_w;
            state_q <= ST_SRCH_CMP;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SRCH_CMP: begin
          if (rd_ext == arg_ext) begin
            res_q   <= mid_ext[VAL_W-1:0];
            ok_q    <= 1'b1;
            state_q <= ST_DONE;
          end else if (arg_ext > rd_ext) begin
            lo_q    <= CW'(mid_q) + CW'(1);
            state_q <= ST_SRCH_ADDR;
          end else begin
            hix_q   <= CW'(mid_q);
            state_q <= ST_SRCH_ADDR;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_res_q   <= res_q;
            out_ok_q    <= ok_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // build result is the final count
      if (state_q == ST_BUILD && build_last) begin
        res_q <= cnt_ext[VAL_W-1:0] + VAL_W'(ram_we);
        ok_q  <= 1'b1;
      end
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign found_o        = out_ok_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_ADDR || state_q == ST_SRCH_CMP) |->
      (lo_q <= hix_q && hix_q <= cnt_q))
    else $error("search window outside table");

  a_probe_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SRCH_CMP |-> (CW'(mid_q) >= lo_q && CW'(mid_q) < hix_q))
    else $error("probe index outside search window");

  a_build_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BUILD && build_last) |=> (state_q == ST_DONE && ok_q))
    else $error("build did not finish with found set");

endmodule

/* design/fwbt_ram.sv */
// ----------------------------------------------------------------------------
// fwbt_ram: generic single-port RAM
// One access per cycle, read data registered; a write also returns the old contents. No reset on contents.
// ----------------------------------------------------------------------------
module fwbt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
